[design/sensor_frame_crop_and_binning_unit_macros.svh]
// Assertion macros for the sensor frame crop and binning unit.
`ifndef SENSOR_FRAME_CROP_AND_BINNING_UNIT_MACROS_SVH
`define SENSOR_FRAME_CROP_AND_BINNING_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SFCB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SFCB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sfcb_pkg.sv]
// Shared constants, types and the divide helper function of the crop and binning unit.
package sfcb_pkg;

  localparam int RAW_ROW_BYTES      = 1558;
  localparam int MAX_WIDTH          = 1280;
  localparam int MAX_HEIGHT         = 1024;
  localparam int LEFT_MARGIN        = 20;
  localparam int SENSOR_CENTER_ROWS = 1024;
  localparam int PIXEL_MAX          = 255;
  localparam int ROW_LIMIT          = 2047;
  localparam int COLSUM_DEPTH       = MAX_WIDTH / 2;

  localparam int PIX_W     = 8;
  localparam int POS_W     = 11;
  localparam int SUM_W     = 12;
  localparam int BIN_W     = 3;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int WR_W      = $clog2(MAX_HEIGHT);
  localparam int COL_AW    = $clog2(COLSUM_DEPTH);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int DIV3_RECIP = 2731;
  localparam int DIV3_SHIFT = 13;
  localparam int PROD_W     = POS_W + DIV3_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_FACTOR = 2'd0,
    CFG_OUT_WIDTH  = 2'd1,
    CFG_OUT_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]       bin_m1;
    logic [POS_W-1:0] pw;
    logic [POS_W-1:0] ph;
    logic [POS_W-1:0] start;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fs;
    logic             win;
    logic             last;
    logic [POS_W-1:0] wc;
    logic [WR_W-1:0]  wr;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic            full;
    logic [Q_CW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [POS_W-1:0] quot;
    logic [1:0]       rem;
  } divr_t;

  // Divide by the bin factor (1 to 4); divide by three via reciprocal multiply.
  function automatic divr_t div_by_bin(input logic [POS_W-1:0] value,
                                       input logic [1:0] bin_m1);
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  q3;
    logic [POS_W+1:0]  back3;
    logic [POS_W-1:0]  rem3;
    divr_t             r;
    prod  = PROD_W'(value) * PROD_W'(DIV3_RECIP);
    q3    = POS_W'(prod >> DIV3_SHIFT);
    back3 = (POS_W+2)'(q3) * (POS_W+2)'(3);
    rem3  = value - POS_W'(back3);
    case (bin_m1)
      2'd0: begin
        r.quot = value;
        r.rem  = 2'd0;
      end
      2'd1: begin
        r.quot = value >> 1;
        r.rem  = {1'b0, value[0]};
      end
      2'd2: begin
        r.quot = q3;
        r.rem  = rem3[1:0];
      end
      default: begin
        r.quot = value >> 2;
        r.rem  = value[1:0];
      end
    endcase
    return r;
  endfunction

endpackage

[design/sfcb_cfg.sv]
// Configuration registers and derived window geometry.
module sfcb_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sfcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfcb_pkg::CFG_W-1:0]          cfg_wdata,
  output sfcb_pkg::cfg_t                      cfg
);
  import sfcb_pkg::*;

  localparam logic [POS_W-1:0] MAXW1 = POS_W'(MAX_WIDTH / 1);
  localparam logic [POS_W-1:0] MAXW2 = POS_W'(MAX_WIDTH / 2);
  localparam logic [POS_W-1:0] MAXW3 = POS_W'(MAX_WIDTH / 3);
  localparam logic [POS_W-1:0] MAXW4 = POS_W'(MAX_WIDTH / 4);
  localparam logic [POS_W-1:0] MAXH1 = POS_W'(MAX_HEIGHT / 1);
  localparam logic [POS_W-1:0] MAXH2 = POS_W'(MAX_HEIGHT / 2);
  localparam logic [POS_W-1:0] MAXH3 = POS_W'(MAX_HEIGHT / 3);
  localparam logic [POS_W-1:0] MAXH4 = POS_W'(MAX_HEIGHT / 4);
  localparam int MUL_W = POS_W + BIN_W;

  logic [BIN_W-1:0] bin_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;

  logic [1:0]       bin_m1;
  logic [BIN_W-1:0] bin;
  logic [POS_W-1:0] maxw;
  logic [POS_W-1:0] maxh;
  logic [POS_W-1:0] w;
  logic [POS_W-1:0] h;
  logic [MUL_W-1:0] pw_full;
  logic [MUL_W-1:0] ph_full;
  logic [POS_W-1:0] ph;
  logic [POS_W-1:0] gap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r    <= BIN_W'(1);
      width_r  <= CFG_W'(MAX_WIDTH);
      height_r <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BIN_FACTOR: bin_r    <= cfg_wdata[BIN_W-1:0];
        CFG_OUT_WIDTH:  width_r  <= cfg_wdata;
        CFG_OUT_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bin_r == '0) begin
      bin_m1 = 2'd0;
    end else if (bin_r > BIN_W'(4)) begin
      bin_m1 = 2'd3;
    end else begin
      bin_m1 = 2'(bin_r - BIN_W'(1));
    end
    bin = BIN_W'(bin_m1) + BIN_W'(1);
    case (bin_m1)
      2'd0: begin
        maxw = MAXW1;
        maxh = MAXH1;
      end
      2'd1: begin
        maxw = MAXW2;
        maxh = MAXH2;
      end
      2'd2: begin
        maxw = MAXW3;
        maxh = MAXH3;
      end
      default: begin
        maxw = MAXW4;
        maxh = MAXH4;
      end
    endcase
    w       = (width_r == '0 || width_r > maxw) ? maxw : width_r;
    h       = (height_r == '0 || height_r > maxh) ? maxh : height_r;
    pw_full = MUL_W'(w) * MUL_W'(bin);
    ph_full = MUL_W'(h) * MUL_W'(bin);
    ph      = ph_full[POS_W-1:0];
    gap     = (ph <= POS_W'(SENSOR_CENTER_ROWS))
              ? ((POS_W'(SENSOR_CENTER_ROWS) - ph) >> 1) : '0;
    cfg.bin_m1 = bin_m1;
    cfg.pw     = pw_full[POS_W-1:0];
    cfg.ph     = ph;
    cfg.start  = POS_W'(LEFT_MARGIN) + gap;
  end

endmodule

[design/sfcb_front.sv]
// Front end: raw position tracking and window classification of each beat.
module sfcb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfcb_pkg::PIX_W-1:0]    in_raw_pixel,
  input  logic                          in_frame_start,
  input  sfcb_pkg::cfg_t                cfg,
  input  sfcb_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output sfcb_pkg::item_t               q_item
);
  import sfcb_pkg::*;

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic             accept;
  logic [POS_W-1:0] col_base;
  logic [POS_W-1:0] row_base;
  logic [POS_W-1:0] col_inc;
  logic [POS_W-1:0] wc;
  logic [POS_W-1:0] wr;
  logic [POS_W:0]   wc_wrap;
  logic             has_pos;
  logic             win;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    col_base = in_frame_start ? '0 : col_r;
    row_base = in_frame_start ? '0 : row_r;
    wc_wrap  = (POS_W+1)'(col_base) + (POS_W+1)'(RAW_ROW_BYTES) - (POS_W+1)'(cfg.start);
    if (col_base >= cfg.start) begin
      has_pos = 1'b1;
      wr      = row_base;
      wc      = col_base - cfg.start;
    end else if (row_base != '0) begin
      has_pos = 1'b1;
      wr      = row_base - POS_W'(1);
      wc      = wc_wrap[POS_W-1:0];
    end else begin
      has_pos = 1'b0;
      wr      = row_base;
      wc      = col_base;
    end
    win = has_pos && wr < cfg.ph && wc < cfg.pw && wc < POS_W'(RAW_ROW_BYTES);

    q_item.pix  = in_raw_pixel;
    q_item.fs   = in_frame_start;
    q_item.win  = win;
    q_item.last = (wr == cfg.ph - POS_W'(1)) && (wc == cfg.pw - POS_W'(1));
    q_item.wc   = wc;
    q_item.wr   = wr[WR_W-1:0];
    q_push      = accept && (win || in_frame_start);

    // Advance the raw position; row count holds at its limit.
    col_inc = col_base + POS_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc == POS_W'(RAW_ROW_BYTES)) begin
        col_nxt = '0;
        row_nxt = (row_base < POS_W'(ROW_LIMIT)) ? row_base + POS_W'(1) : row_base;
      end else begin
        col_nxt = col_inc;
        row_nxt = row_base;
      end
    end
  end

endmodule

[design/sfcb_queue.sv]
// Short FIFO between the front end and the binning back end.
module sfcb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfcb_pkg::item_t   push_item,
  input  logic              pop,
  output sfcb_pkg::item_t   head,
  output sfcb_pkg::q_stat_t stat
);
  import sfcb_pkg::*;

  item_t           entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = entry_r[rd_ptr_r];
  assign stat.valid = count_r != '0;
  assign stat.full  = count_r == Q_CW'(Q_DEPTH);
  assign stat.count = count_r;

endmodule

[design/sfcb_back.sv]
// Back end: block summing, column sum line buffer and output register.
module sfcb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfcb_pkg::cfg_t                cfg,
  input  sfcb_pkg::q_stat_t             q_stat,
  input  sfcb_pkg::item_t               head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfcb_pkg::PIX_W-1:0]    out_pixel_out,
  output logic                          out_frame_last
);
  import sfcb_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]  hsum;
    logic [COL_AW-1:0] col;
    logic              col_ok;
    logic              blk;
    logic              phase_nz;
    logic              phase_last;
    logic              last;
  } s1_t;

  logic [SUM_W-1:0] colsum_mem [COLSUM_DEPTH];

  s1_t              s1_r, s1_nxt;
  logic             s1_v_r;
  logic [SUM_W-1:0] hsum_r;
  logic [SUM_W-1:0] rd_data_r;
  logic             fwd_hit_r;
  logic [SUM_W-1:0] fwd_data_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;

  divr_t             cdiv;
  divr_t             rdiv;
  logic [SUM_W-1:0]  hsum_base;
  logic [SUM_W-1:0]  hsum_upd;
  logic              col_ok_h;
  logic [COL_AW-1:0] col_idx_h;
  logic [SUM_W-1:0]  mem_q;
  logic [SUM_W-1:0]  total;
  logic              store;
  logic              emit;
  logic              s1_go;

  always_comb begin
    cdiv      = div_by_bin(head.wc, cfg.bin_m1);
    rdiv      = div_by_bin(POS_W'(head.wr), cfg.bin_m1);
    hsum_base = head.fs ? '0 : hsum_r;
    hsum_upd  = (cdiv.rem == 2'd0) ? SUM_W'(head.pix) : hsum_base + SUM_W'(head.pix);
    col_ok_h  = cdiv.quot < POS_W'(COLSUM_DEPTH);
    col_idx_h = cdiv.quot[COL_AW-1:0];

    s1_nxt.hsum       = hsum_upd;
    s1_nxt.col        = col_idx_h;
    s1_nxt.col_ok     = col_ok_h;
    s1_nxt.blk        = head.win && (cdiv.rem == cfg.bin_m1);
    s1_nxt.phase_nz   = rdiv.rem != 2'd0;
    s1_nxt.phase_last = rdiv.rem == cfg.bin_m1;
    s1_nxt.last       = head.last;

    mem_q = fwd_hit_r ? fwd_data_r : rd_data_r;
    total = s1_r.hsum + ((s1_r.phase_nz && s1_r.col_ok) ? mem_q : '0);
    store = s1_v_r && s1_r.blk && !s1_r.phase_last && s1_r.col_ok;
    emit  = s1_v_r && s1_r.blk && s1_r.phase_last;
    s1_go = s1_v_r && (!emit || !out_valid_r || out_ready);
    q_pop = q_stat.valid && (!s1_v_r || s1_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      hsum_r      <= '0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop || (s1_v_r && !s1_go);
      if (q_pop) begin
        hsum_r    <= head.win ? hsum_upd : hsum_base;
        fwd_hit_r <= store && s1_go && col_ok_h && (col_idx_h == s1_r.col);
      end
      if (s1_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= total;
    end
    if (s1_go && emit) begin
      out_pix_r  <= (total > SUM_W'(PIXEL_MAX)) ? PIX_W'(PIXEL_MAX) : total[PIX_W-1:0];
      out_last_r <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && store) begin
      colsum_mem[s1_r.col] <= total;
    end
    if (q_pop && col_ok_h) begin
      rd_data_r <= colsum_mem[col_idx_h];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule

[design/sensor_frame_crop_and_binning_unit.sv]
// Top level of the sensor frame crop and binning unit.
// Takes one raw sensor byte per beat and sustains one beat per clock cycle;
// a result reaches the output through the queue, stage-one and output
// registers once its last raw byte is accepted. While a result waits, bytes
// outside the window are still taken and window bytes fill the four-entry
// queue before the input stalls. The rate is set by the column sum line
// buffer (640 x 12 bits), which gives one read and one write per cycle,
// with a bypass for a write and read of the same column. Frames are cropped
// to a window of height*bin rows from the top and width*bin columns,
// starting at the left margin plus half of what the window height leaves of
// a 1024-row sensor area; bin 2 to 4 sums each block, saturated at 255, and
// emits it on the block's bottom-right byte. The line buffer needs no
// clearing pass: each column is written by the first block row of a frame.
// Write the configuration registers only while no beats are in flight.
`include "sensor_frame_crop_and_binning_unit_macros.svh"

module sensor_frame_crop_and_binning_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sfcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfcb_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sfcb_pkg::PIX_W-1:0]        in_raw_pixel,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sfcb_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                              out_frame_last
);
  import sfcb_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  item_t   q_item;
  item_t   q_head;
  logic    q_push;
  logic    q_pop;

  sfcb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfcb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_pixel   (in_raw_pixel),
    .in_frame_start (in_frame_start),
    .cfg            (cfg),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  sfcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  sfcb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_stat         (q_stat),
    .head           (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

  `SFCB_ASSERT_IMP(a_pop_needs_entry, q_pop, q_stat.count != '0, "queue popped while empty")
  `SFCB_ASSERT_NXT(a_push_grows_queue, q_push && !q_pop, q_stat.count == $past(q_stat.count) + Q_CW'(1), "queue count did not grow on push")
  `SFCB_ASSERT_IMP(a_window_bounds, 1'b1, cfg.pw <= POS_W'(MAX_WIDTH) && cfg.ph <= POS_W'(MAX_HEIGHT) && cfg.start >= POS_W'(LEFT_MARGIN), "window geometry out of bounds")

endmodule

[dv/tb_sensor_frame_crop_and_binning_unit.sv]
// Testbench for the sensor frame crop and binning unit: windowing, binning, saturation, frame end.
`timescale 1ns / 1ps

module tb_sensor_frame_crop_and_binning_unit;
  import sfcb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT     = 4_000_000;

  typedef enum int {PIX_ANY, PIX_LOW, PIX_RAIL} pix_style_t;
  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fs;
  } raw_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } binned_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_raw_pixel = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_frame_last;

  // mirror of the block's registers and state
  logic [BIN_W-1:0] mirror_bin = 3'd1;
  logic [CFG_W-1:0] mirror_w = 11'd1280;
  logic [CFG_W-1:0] mirror_h = 11'd1024;
  logic [POS_W-1:0] pos_col = '0;
  logic [POS_W-1:0] pos_row = '0;
  logic [SUM_W-1:0] row_sum = '0;
  logic [SUM_W-1:0] col_acc [COLSUM_DEPTH];

  raw_beat_t  raw_q[$];
  binned_px_t binned_q[$];
  raw_beat_t  drive_beat;
  binned_px_t px_want;

  int          beats_pushed = 0;
  int          beats_taken = 0;
  int          window_beats = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycles = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done;
  int          hold_left = 0;

  sensor_frame_crop_and_binning_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_pixel  (in_raw_pixel),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_last(out_frame_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void window_geom(output int b, output int pw, output int ph,
                                      output int org);
    int w, h;
    b = mirror_bin;
    if (b < 1) b = 1;
    if (b > 4) b = 4;
    w = mirror_w;
    h = mirror_h;
    if (w < 1 || w > MAX_WIDTH / b) w = MAX_WIDTH / b;
    if (h < 1 || h > MAX_HEIGHT / b) h = MAX_HEIGHT / b;
    pw = w * b;
    ph = h * b;
    org = LEFT_MARGIN + (ph <= SENSOR_CENTER_ROWS ? (SENSOR_CENTER_ROWS - ph) / 2 : 0);
  endfunction

  function automatic int frame_span(input int block_rows);
    int b, pw, ph, org;
    window_geom(b, pw, ph, org);
    return org + (block_rows * b - 1) * RAW_ROW_BYTES + pw;
  endfunction

  task automatic crop_bin_byte(input logic [PIX_W-1:0] pix, input logic fs);
    int b, pw, ph, org, wr, wc, cx, col, phase, total;
    bit placed;
    binned_px_t px;
    if (fs) begin
      pos_col = '0;
      pos_row = '0;
      row_sum = '0;
    end
    window_geom(b, pw, ph, org);
    placed = 1'b1;
    wr = 0;
    wc = 0;
    if (int'(pos_col) >= org) begin
      wr = int'(pos_row);
      wc = int'(pos_col) - org;
    end else if (pos_row != 0) begin
      wr = int'(pos_row) - 1;
      wc = int'(pos_col) + RAW_ROW_BYTES - org;
    end else begin
      placed = 1'b0;
    end
    if (int'(pos_col) == RAW_ROW_BYTES - 1) begin
      pos_col = '0;
      if (int'(pos_row) < ROW_LIMIT) pos_row = pos_row + 1'b1;
    end else begin
      pos_col = pos_col + 1'b1;
    end
    if (placed && wr < ph && wc < pw && wc < RAW_ROW_BYTES) begin
      window_beats++;
      phase = wr % b;
      cx = wc % b;
      col = wc / b;
      if (cx == 0) row_sum = SUM_W'(pix);
      else row_sum = SUM_W'(row_sum + pix);
      if (cx == b - 1) begin
        total = row_sum;
        if (phase != 0 && col < COLSUM_DEPTH) total = (total + col_acc[col]) & 'hFFF;
        if (phase != b - 1) begin
          if (col < COLSUM_DEPTH) col_acc[col] = SUM_W'(total);
        end else begin
          px.pix = PIX_W'(total > PIXEL_MAX ? PIXEL_MAX : total);
          px.last = (wr == ph - 1 && wc == pw - 1);
          binned_q.push_back(px);
        end
      end
    end
  endtask

  task automatic queue_frame(input int len, input pix_style_t style, input bit open_new,
                             input bit noisy);
    raw_beat_t beat;
    for (int i = 0; i < len; i++) begin
      case (style)
        PIX_ANY: beat.pix = PIX_W'($urandom_range(255));
        PIX_LOW: beat.pix = PIX_W'($urandom_range(15));
        default: beat.pix = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      if (i == 0) beat.fs = open_new;
      else beat.fs = noisy && ($urandom_range(31) == 0);
      raw_q.push_back(beat);
      beats_pushed++;
    end
  endtask

  task automatic settle();
    while (beats_taken != beats_pushed || binned_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_FREE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      FLOW_SEND_IDLE: begin
        send_idle_pct = 75;
        recv_stall_pct = 0;
      end
      FLOW_RECV_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 75;
      end
      default: begin
        send_idle_pct = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BIN_FACTOR: mirror_bin = val[BIN_W-1:0];
      CFG_OUT_WIDTH:  mirror_w = val;
      CFG_OUT_HEIGHT: mirror_h = val;
      default: ;
    endcase
  endtask

  task automatic program_window(input logic [CFG_W-1:0] bin_v, input logic [CFG_W-1:0] w_v,
                                input logic [CFG_W-1:0] h_v, input bit with_spare);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (with_spare) write_reg(CFG_SPARE, 11'h7FF);
    write_reg(CFG_BIN_FACTOR, bin_v);
    write_reg(CFG_OUT_WIDTH, w_v);
    write_reg(CFG_OUT_HEIGHT, h_v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        crop_bin_byte(in_raw_pixel, in_frame_start);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (raw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_beat = raw_q.pop_front();
          in_valid <= 1'b1;
          in_raw_pixel <= drive_beat.pix;
          in_frame_start <= drive_beat.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (binned_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual pixel %0d last %0b",
                   $time, out_pixel_out, out_frame_last);
          mismatches++;
        end else begin
          px_want = binned_q.pop_front();
          if (out_pixel_out !== px_want.pix) begin
            $display("%0t: pixel_out expected %0d actual %0d",
                     $time, px_want.pix, out_pixel_out);
            mismatches++;
          end
          if (out_frame_last !== px_want.last) begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, px_want.last, out_frame_last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("sensor_frame_crop_and_binning_unit verification failed");
      $finish;
    end
  end

  initial begin
    int bin_raw, beff, w_raw, h_raw, b, pw, ph, org, span, len, kind;
    int phase_n, phase_bytes, base, block_rows;
    bit first, open_new;
    pix_style_t style;
    for (int i = 0; i < COLSUM_DEPTH; i++) col_acc[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset window, long receiver hold, sender pause mid-frame
    set_flow(FLOW_FREE);
    queue_frame(320, PIX_ANY, 1'b1, 1'b0);
    hold_arm = 1'b1;
    settle();
    queue_frame(40, PIX_RAIL, 1'b0, 1'b0);

    program_window(11'd2, 11'd2, 11'd512, 1'b0);
    queue_frame(frame_span(1), PIX_RAIL, 1'b1, 1'b0);
    program_window(11'd1, 11'd3, 11'd1, 1'b0);
    queue_frame(frame_span(1), PIX_ANY, 1'b1, 1'b0);
    program_window(11'd3, 11'd1, 11'd1, 1'b0);
    queue_frame(frame_span(1), PIX_LOW, 1'b1, 1'b0);
    program_window(11'd7, 11'd0, 11'd2047, 1'b0);
    queue_frame(frame_span(1), PIX_LOW, 1'b1, 1'b0);
    program_window(11'd5, 11'd2047, 11'd1, 1'b0);
    queue_frame(frame_span(1), PIX_ANY, 1'b1, 1'b0);
    program_window(11'd0, 11'd1280, 11'd0, 1'b0);
    queue_frame(frame_span(1) + RAW_ROW_BYTES, PIX_RAIL, 1'b1, 1'b0);
    program_window(11'h7FA, 11'd640, 11'd1, 1'b1);
    queue_frame(frame_span(1), PIX_ANY, 1'b1, 1'b0);

    settle();
    base = window_beats;
    for (phase_n = 0; phase_n < 24 && (phase_n < 8 || window_beats - base < 1950);
         phase_n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: bin_raw = 1;
        4, 9: bin_raw = 2;
        5: bin_raw = 3;
        6: bin_raw = 4;
        7: bin_raw = 0;
        default: bin_raw = $urandom_range(5, 7);
      endcase
      beff = (bin_raw == 0) ? 1 : (bin_raw > 4 ? 4 : bin_raw);
      case ($urandom_range(9))
        0: w_raw = 0;
        1: w_raw = $urandom_range(2047);
        2: w_raw = MAX_WIDTH / beff - $urandom_range(2);
        default: w_raw = $urandom_range(1, 48);
      endcase
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(2))
          0: h_raw = 0;
          1: h_raw = MAX_HEIGHT / beff;
          default: h_raw = $urandom_range(MAX_HEIGHT / beff + 1, 2047);
        endcase
      end else begin
        h_raw = $urandom_range(1, 3);
      end
      program_window(CFG_W'(bin_raw), CFG_W'(w_raw), CFG_W'(h_raw), 1'b0);
      set_flow(flow_t'(phase_n % 4));
      window_geom(b, pw, ph, org);
      block_rows = (ph <= 4) ? ph / b : 1;
      span = frame_span(block_rows);
      phase_bytes = 0;
      first = 1'b1;
      while (phase_bytes < 3000) begin
        kind = $urandom_range(9);
        style = pix_style_t'($urandom_range(2));
        if (kind <= 6) len = span + $urandom_range(6);
        else if (kind <= 8) len = $urandom_range(1, span);
        else len = $urandom_range(1, 300);
        open_new = first || kind != 9 || $urandom_range(1);
        queue_frame(len, style, open_new, kind == 9);
        phase_bytes += len;
        first = 1'b0;
        if ($urandom_range(15) == 0) settle();
      end
    end

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sensor_frame_crop_and_binning_unit verification clean");
    end else begin
      $display("sensor_frame_crop_and_binning_unit verification failed");
    end
    $finish;
  end

endmodule
